### design/ttc_pkg.sv
// Package for the triangle tangent calculator: shared types and constants.
// No dependencies.
package ttc_pkg;

  localparam int PosW = 24;
  localparam int UvW  = 18;
  localparam int IdxW = 10;
  localparam int TanW = 16;
  localparam int XyW  = 2 * PosW;
  localparam int ZuvW = PosW + 2 * UvW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_LAT_C,
    ST_DELTA,
    ST_MUL_W,
    ST_SUB_W,
    ST_NORM,
    ST_SQ,
    ST_SUM,
    ST_SQRT,
    ST_DIV,
    ST_DONE
  } ttc_state_t;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TRI   = 1'b1;

endpackage

### design/ttc_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module ttc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### design/ttc_sqrt.sv
// Iterative integer square root, one result bit per cycle (62-bit radicand).
// Depends on nothing.
module ttc_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [61:0] radicand,
  output logic        done,
  output logic [30:0] root
);
  logic [61:0] rem_r, rem_nxt;
  logic [30:0] root_r, root_nxt;
  logic [61:0] n_r, n_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic [32:0] part;

  // classic restoring digit recurrence: bring two bits down each step
  always_comb begin
    rem_nxt  = rem_r;
    root_nxt = root_r;
    n_nxt    = n_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    // flag the cycle after the last step, when the root is complete
    done_nxt = busy_r && (cnt_r == 5'd30);
    part     = {rem_r[30:0], n_r[61:60]};
    trial    = {root_r, 2'b01};
    if (start) begin
      rem_nxt  = '0;
      root_nxt = '0;
      n_nxt    = radicand;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = {n_r[59:0], 2'b00};
      if (part >= trial) begin
        rem_nxt  = {29'd0, part - trial};
        root_nxt = {root_r[29:0], 1'b1};
      end else begin
        rem_nxt  = {29'd0, part};
        root_nxt = {root_r[29:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd30) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    n_r    <= n_nxt;
  end

  assign root = root_r;
  assign done = done_r;
endmodule

### design/ttc_div.sv
// Iterative restoring divider for the three tangent components, shared.
// Quotient of a 46-bit dividend by a 31-bit divisor, one bit per cycle.
module ttc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [45:0] dividend,
  input  logic [30:0] divisor,
  output logic        done,
  output logic [45:0] quotient
);
  logic [45:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [30:0] d_r, d_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] part;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    // flag the cycle after the last step, when the quotient is complete
    done_nxt = busy_r && (cnt_r == 6'd45);
    part     = {rem_r[30:0], q_r[45]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (part >= {1'b0, d_r}) begin
        rem_nxt = part - {1'b0, d_r};
        q_nxt   = {q_r[44:0], 1'b1};
      end else begin
        rem_nxt = part;
        q_nxt   = {q_r[44:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd45) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign quotient = q_r;
  assign done     = done_r;
endmodule

### design/triangle_tangent_calc.sv
// Top level of the triangle tangent calculator.
// Depends on ttc_pkg, ttc_ram, ttc_sqrt and ttc_div.
//
// A triangle's result follows three store reads, edge and determinant
// arithmetic, a 31-step square root and three 46-step divisions on one
// shared divider, which set the rate; a degenerate triangle skips the root
// and the divisions. The next item is taken the cycle after the result
// leaves. Reading a vertex entry that was never written returns garbage.
// Corner indices at or above VERTEX_DEPTH read as a zero entry and writes
// there are dropped.
module triangle_tangent_calc #(
  parameter int VERTEX_DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_command,
  input  logic [ttc_pkg::IdxW-1:0]  in_vertex_index,
  input  logic signed [23:0]        in_pos_x,
  input  logic signed [23:0]        in_pos_y,
  input  logic signed [23:0]        in_pos_z,
  input  logic signed [17:0]        in_tex_u,
  input  logic signed [17:0]        in_tex_v,
  input  logic [ttc_pkg::IdxW-1:0]  in_corner_a,
  input  logic [ttc_pkg::IdxW-1:0]  in_corner_b,
  input  logic [ttc_pkg::IdxW-1:0]  in_corner_c,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [15:0]        out_tangent_x,
  output logic signed [15:0]        out_tangent_y,
  output logic signed [15:0]        out_tangent_z,
  output logic [ttc_pkg::IdxW-1:0]  out_target_a,
  output logic [ttc_pkg::IdxW-1:0]  out_target_b,
  output logic [ttc_pkg::IdxW-1:0]  out_target_c,
  output logic                      out_degenerate
);
  import ttc_pkg::*;

  localparam int AW = $clog2(VERTEX_DEPTH);

  ttc_state_t state_r, state_nxt;

  logic [IdxW-1:0] ca_r, cb_r, cc_r;
  logic            oob_r;       // range flag of the corner read last cycle
  logic [AW-1:0]   ram_addr;
  logic            ram_we;
  logic [XyW-1:0]  xy_rd;
  logic [ZuvW-1:0] zuv_rd;
  logic            in_fire;
  logic            wr_ok;
  logic            rd_oob;
  logic [IdxW-1:0] rd_idx;

  // latched vertex fields, index 0..2 = a,b,c
  logic signed [PosW-1:0] px_r [3];
  logic signed [PosW-1:0] py_r [3];
  logic signed [PosW-1:0] pz_r [3];
  logic signed [UvW-1:0]  pu_r [3];
  logic signed [UvW-1:0]  pv_r [3];
  logic [1:0]             ld_sel;
  logic                   ld_en;

  logic signed [PosW:0]  e1_r [3];
  logic signed [PosW:0]  e2_r [3];
  logic signed [UvW:0]   d1u_r, d1v_r, d2u_r, d2v_r;
  logic signed [44:0]    pa_r [3];
  logic signed [44:0]    pb_r [3];
  logic signed [37:0]    dpa_r, dpb_r;
  logic signed [45:0]    w_r [3];
  logic                  detneg_r, detz_r;
  logic [45:0]           mag [3];
  logic                  wneg [3];
  logic [29:0]           nm_r [3];
  logic [59:0]           sq_r [3];
  logic [61:0]           sum_c;
  logic                  degen_c;
  logic [1:0]            dcnt_r;
  logic [15:0]           t_r [3];

  logic                  sq_start, sq_done, dv_start, dv_done;
  logic [30:0]           len;
  logic [45:0]           quo;
  logic [45:0]           dv_num;
  logic [45:0]           mmax;
  logic [5:0]            lead;
  logic [45:0]           wabs [3];

  logic                  oval_r;

  assign in_fire = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE) && !oval_r;
  assign wr_ok = ({{(32-IdxW){1'b0}}, in_vertex_index} < VERTEX_DEPTH);

  always_comb begin
    unique case (state_r)
      ST_RD_A: rd_idx = ca_r;
      ST_RD_B: rd_idx = cb_r;
      default: rd_idx = cc_r;
    endcase
  end
  assign rd_oob = ({{(32-IdxW){1'b0}}, rd_idx} >= VERTEX_DEPTH);

  always_comb begin
    ram_we   = in_fire && (in_command == CMD_WRITE) && wr_ok;
    ram_addr = in_fire ? AW'(in_vertex_index) : AW'(rd_idx);
  end

  ttc_ram #(.WIDTH(XyW), .DEPTH(VERTEX_DEPTH)) u_xy_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr),
    .wdata({in_pos_y, in_pos_x}), .rdata(xy_rd)
  );
  ttc_ram #(.WIDTH(ZuvW), .DEPTH(VERTEX_DEPTH)) u_zuv_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr),
    .wdata({in_tex_v, in_tex_u, in_pos_z}), .rdata(zuv_rd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire && in_command == CMD_TRI) state_nxt = ST_RD_A;
      ST_RD_A:  state_nxt = ST_RD_B;
      ST_RD_B:  state_nxt = ST_RD_C;
      ST_RD_C:  state_nxt = ST_LAT_C;
      ST_LAT_C: state_nxt = ST_DELTA;
      ST_DELTA: state_nxt = ST_MUL_W;
      ST_MUL_W: state_nxt = ST_SUB_W;
      ST_SUB_W: state_nxt = ST_NORM;
      ST_NORM:  state_nxt = degen_c ? ST_DONE : ST_SQ;
      ST_SQ:    state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_SQRT;
      ST_SQRT:  if (sq_done) state_nxt = ST_DIV;
      ST_DIV:   if (dv_done && dcnt_r == 2'd2) state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ld_en    = 1'b0;
    ld_sel   = 2'd0;
    sq_start = 1'b0;
    dv_start = 1'b0;
    unique case (state_r)
      ST_RD_B:  begin ld_en = 1'b1; ld_sel = 2'd0; end
      ST_RD_C:  begin ld_en = 1'b1; ld_sel = 2'd1; end
      ST_LAT_C: begin ld_en = 1'b1; ld_sel = 2'd2; end
      ST_SUM:   sq_start = 1'b1;
      ST_SQRT:  dv_start = sq_done;
      ST_DIV:   dv_start = dv_done && (dcnt_r != 2'd2);
      default:  ;
    endcase
  end

  // squares land at the end of ST_SQ; the root takes their sum in ST_SUM
  assign sum_c = 62'(sq_r[0]) + 62'(sq_r[1]) + 62'(sq_r[2]);

  ttc_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(sum_c),
    .done(sq_done), .root(len)
  );

  // dividend: m*32768 + len/2 ; selected by component counter
  always_comb begin
    logic [1:0] k;
    k = sq_done ? 2'd0 : (dcnt_r + 2'd1);
    dv_num = {1'b0, nm_r[k], 15'd0} + {16'd0, len[30:1]};
  end

  ttc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_num),
    .divisor(len), .done(dv_done), .quotient(quo)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wabs[i] = w_r[i][45] ? 46'(-w_r[i]) : 46'(w_r[i]);
    end
  end

  // leading one position of the largest magnitude
  always_comb begin
    mmax = mag[0];
    if (mag[1] > mmax) mmax = mag[1];
    if (mag[2] > mmax) mmax = mag[2];
    lead = '0;
    for (int b = 0; b < 46; b++) begin
      if (mmax[b]) lead = 6'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      oval_r  <= 1'b0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE) begin
        oval_r <= 1'b1;
      end else if (out_ready) begin
        oval_r <= 1'b0;
      end
      if (sq_done) begin
        dcnt_r <= '0;
      end else if (dv_done) begin
        dcnt_r <= dcnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    oob_r <= rd_oob;
    if (in_fire) begin
      ca_r <= in_corner_a;
      cb_r <= in_corner_b;
      cc_r <= in_corner_c;
    end
    if (ld_en) begin
      // a corner out of range reads as a zero entry
      px_r[ld_sel] <= oob_r ? '0 : xy_rd[PosW-1:0];
      py_r[ld_sel] <= oob_r ? '0 : xy_rd[XyW-1:PosW];
      pz_r[ld_sel] <= oob_r ? '0 : zuv_rd[PosW-1:0];
      pu_r[ld_sel] <= oob_r ? '0 : zuv_rd[PosW+UvW-1:PosW];
      pv_r[ld_sel] <= oob_r ? '0 : zuv_rd[ZuvW-1:PosW+UvW];
    end
    if (state_r == ST_DELTA) begin
      e1_r[0] <= (PosW+1)'(px_r[1]) - (PosW+1)'(px_r[0]);
      e1_r[1] <= (PosW+1)'(py_r[1]) - (PosW+1)'(py_r[0]);
      e1_r[2] <= (PosW+1)'(pz_r[1]) - (PosW+1)'(pz_r[0]);
      e2_r[0] <= (PosW+1)'(px_r[2]) - (PosW+1)'(px_r[0]);
      e2_r[1] <= (PosW+1)'(py_r[2]) - (PosW+1)'(py_r[0]);
      e2_r[2] <= (PosW+1)'(pz_r[2]) - (PosW+1)'(pz_r[0]);
      d1u_r <= (UvW+1)'(pu_r[1]) - (UvW+1)'(pu_r[0]);
      d1v_r <= (UvW+1)'(pv_r[1]) - (UvW+1)'(pv_r[0]);
      d2u_r <= (UvW+1)'(pu_r[2]) - (UvW+1)'(pu_r[0]);
      d2v_r <= (UvW+1)'(pv_r[2]) - (UvW+1)'(pv_r[0]);
    end
    if (state_r == ST_MUL_W) begin
      for (int i = 0; i < 3; i++) begin
        pa_r[i] <= 45'(d2v_r) * 45'(e1_r[i]);
        pb_r[i] <= 45'(d1v_r) * 45'(e2_r[i]);
      end
      dpa_r <= 38'(d1u_r) * 38'(d2v_r);
      dpb_r <= 38'(d2u_r) * 38'(d1v_r);
    end
    if (state_r == ST_SUB_W) begin
      for (int i = 0; i < 3; i++) begin
        w_r[i] <= 46'(pa_r[i]) - 46'(pb_r[i]);
      end
      detneg_r <= dpa_r < dpb_r;
      detz_r   <= dpa_r == dpb_r;
    end
    if (state_r == ST_NORM) begin
      // det's sign only flips w, which the magnitude ignores
      for (int i = 0; i < 3; i++) begin
        if (lead >= 6'd30) begin
          nm_r[i] <= 30'(mag[i] >> (lead - 6'd29));
        end else begin
          nm_r[i] <= 30'(mag[i] << (6'd29 - lead));
        end
      end
    end
    if (state_r == ST_SQ) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= nm_r[i] * nm_r[i];
      end
    end
    if (dv_done) begin
      t_r[dcnt_r] <= (quo > 46'd32767) ? 16'd32767 : 16'(quo);
    end
    if (state_r == ST_DONE) begin
      out_target_a   <= ca_r;
      out_target_b   <= cb_r;
      out_target_c   <= cc_r;
      out_degenerate <= degen_c;
      out_tangent_x  <= degen_c ? '0 : (wneg[0] ? -t_r[0] : t_r[0]);
      out_tangent_y  <= degen_c ? '0 : (wneg[1] ? -t_r[1] : t_r[1]);
      out_tangent_z  <= degen_c ? '0 : (wneg[2] ? -t_r[2] : t_r[2]);
    end
  end

  // w is registered in ST_SUB_W; magnitudes derive combinationally from w_r
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]  = wabs[i];
      wneg[i] = w_r[i][45] ^ detneg_r;
    end
  end

  // degenerate when det is zero or w is all zero
  assign degen_c = detz_r || (w_r[0] == '0 && w_r[1] == '0 && w_r[2] == '0);

  assign out_valid = oval_r;
endmodule

### design/ttc_checker.sv
// Port-level checker for triangle_tangent_calc, bound to the top level.
// Depends on ttc_pkg.
module ttc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic signed [15:0] out_tangent_x,
  input logic signed [15:0] out_tangent_y,
  input logic signed [15:0] out_tangent_z,
  input logic        out_degenerate
);
  import ttc_pkg::*;

  // a degenerate result carries a zero tangent
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_tangent_x == 0 && out_tangent_y == 0 && out_tangent_z == 0)
    else $error("degenerate item with nonzero tangent");

  // no new item is taken while a result waits
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted while result pending");

  // a stalled result stays valid and holds its x tangent component
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tangent_x))
    else $error("result dropped or changed while stalled");

  // reset leaves no result pending
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind triangle_tangent_calc ttc_checker u_ttc_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_tangent_x(out_tangent_x), .out_tangent_y(out_tangent_y),
  .out_tangent_z(out_tangent_z), .out_degenerate(out_degenerate)
);
